[hdl/spcr_pkg.sv]
`default_nettype none

package spcr_pkg;

    localparam int unsigned QW = 32;
    localparam int unsigned NW = 18;
    localparam int unsigned EW = 17;
    localparam int unsigned RW = 31;

    typedef enum logic [2:0] {
        REG_POINT_X  = 3'd0,
        REG_POINT_Y  = 3'd1,
        REG_POINT_Z  = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5,
        REG_EPS      = 3'd6
    } reg_idx_t;

    localparam logic [QW-1:0] POINT_RESET   = 32'd0;
    localparam logic [NW-1:0] NORMAL_X_RESET = 18'd0;
    localparam logic [NW-1:0] NORMAL_Y_RESET = 18'd65536;
    localparam logic [NW-1:0] NORMAL_Z_RESET = 18'd0;
    localparam logic [EW-1:0] EPS_RESET     = 17'd6554;

    typedef struct packed {
        logic [2:0][QW-1:0] point;
        logic [2:0][NW-1:0] normal;
        logic [EW-1:0]      eps;
    } cfg_t;

    typedef struct packed {
        logic [2:0][QW-1:0] pos;
        logic [2:0][QW-1:0] vel;
        logic [RW-1:0]      radius;
        logic               alive;
    } particle_t;

    typedef struct packed {
        logic          hit;
        logic [QW-1:0] s;
        logic [QW-1:0] w;
        logic [RW-1:0] radius;
    } front_t;

    typedef struct packed {
        logic [2:0][QW-1:0] pos_fix;
        logic [2:0][QW-1:0] vel_fix;
        logic               hit;
    } result_t;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        if (a > SAT_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (a < SAT_MIN) begin
            return 32'sh8000_0000;
        end
        return 32'(a);
    endfunction

endpackage

`default_nettype wire

[hdl/spcr_front.sv]
`default_nettype none

module spcr_front #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire spcr_pkg::particle_t in_item,
    input  wire spcr_pkg::cfg_t      cfg,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output spcr_pkg::front_t        out_item
);
    import spcr_pkg::*;

    // stage a: offsets from the plane point
    logic               a_valid_reg;
    logic signed [32:0] a_d_reg [3];
    logic signed [33:0] a_low_y_reg;
    logic signed [31:0] a_v_reg [3];
    logic [RW-1:0]      a_r_reg;
    logic               a_alive_reg;

    // stage b: products with the normal
    logic               b_valid_reg;
    logic signed [51:0] b_tp_reg [3];
    logic signed [50:0] b_sp_reg [3];
    logic signed [49:0] b_vp_reg [3];
    logic [RW-1:0]      b_r_reg;
    logic               b_alive_reg;

    // stage c: dot products, hit test
    logic               c_valid_reg;
    front_t             c_item_reg;

    logic               rdy_a, rdy_b, rdy_c;
    logic signed [32:0] d_next [3];
    logic signed [33:0] low_y_next;
    logic signed [33:0] low [3];
    logic signed [17:0] n [3];
    logic signed [53:0] test_sum;
    logic signed [52:0] sd_sum;
    logic signed [51:0] vd_sum;
    front_t             c_item_next;

    assign rdy_c    = !c_valid_reg || out_ready;
    assign rdy_b    = !b_valid_reg || rdy_c;
    assign rdy_a    = !a_valid_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_next[i] = $signed({in_item.pos[i][QW-1], in_item.pos[i]})
                      - $signed({cfg.point[i][QW-1], cfg.point[i]});
            n[i]      = $signed(cfg.normal[i]);
        end
        low_y_next = 34'(d_next[1]) - $signed({3'b000, in_item.radius});
        low[0] = 34'(a_d_reg[0]);
        low[1] = a_low_y_reg;
        low[2] = 34'(a_d_reg[2]);
    end

    always_comb begin
        test_sum = 54'(b_tp_reg[0]) + 54'(b_tp_reg[1]) + 54'(b_tp_reg[2]);
        sd_sum   = 53'(b_sp_reg[0]) + 53'(b_sp_reg[1]) + 53'(b_sp_reg[2]);
        vd_sum   = 52'(b_vp_reg[0]) + 52'(b_vp_reg[1]) + 52'(b_vp_reg[2]);
        c_item_next.hit    = b_alive_reg && (test_sum < 0);
        c_item_next.s      = sat32(64'(sd_sum >>> FRAC_BITS));
        c_item_next.w      = sat32(64'(vd_sum >>> FRAC_BITS));
        c_item_next.radius = b_r_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                a_valid_reg <= in_valid;
            end
            if (rdy_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (rdy_c) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            for (int i = 0; i < 3; i++) begin
                a_d_reg[i] <= d_next[i];
                a_v_reg[i] <= $signed(in_item.vel[i]);
            end
            a_low_y_reg <= low_y_next;
            a_r_reg     <= in_item.radius;
            a_alive_reg <= in_item.alive;
        end
        if (rdy_b && a_valid_reg) begin
            for (int i = 0; i < 3; i++) begin
                b_tp_reg[i] <= low[i] * n[i];
                b_sp_reg[i] <= a_d_reg[i] * n[i];
                b_vp_reg[i] <= a_v_reg[i] * n[i];
            end
            b_r_reg     <= a_r_reg;
            b_alive_reg <= a_alive_reg;
        end
        if (rdy_c && b_valid_reg) begin
            c_item_reg <= c_item_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

`default_nettype wire

[hdl/spcr_back.sv]
`default_nettype none

module spcr_back #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire spcr_pkg::front_t in_item,
    input  wire spcr_pkg::cfg_t   cfg,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output spcr_pkg::result_t     out_item
);
    import spcr_pkg::*;

    localparam int unsigned CW = ((FRAC_BITS > EW) ? FRAC_BITS : EW) + 2;
    localparam int unsigned PW = CW + QW;
    localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    logic signed [CW-1:0] c_plus, c_minus;
    logic signed [17:0]   n [3];

    // stage d: s times normal, (1-e) times w
    logic               d_valid_reg;
    logic signed [49:0] d_sn_reg [3];
    logic signed [PW-1:0] d_kp_reg;
    logic [RW-1:0]      d_r_reg;
    logic               d_hit_reg;

    // stage e: plane offset u and scaled k
    logic               e_valid_reg;
    logic signed [31:0] e_u_reg [3];
    logic signed [31:0] e_k_reg;
    logic               e_hit_reg;

    // stage f: final products
    logic               f_valid_reg;
    logic signed [PW-1:0] f_pu_reg [3];
    logic signed [49:0] f_pk_reg [3];
    logic               f_hit_reg;

    // stage g: result register
    logic               g_valid_reg;
    result_t            g_item_reg;

    logic               rdy_d, rdy_e, rdy_f, rdy_g;
    logic signed [50:0] sn_neg [3];
    logic signed [51:0] u_wide [3];
    logic signed [31:0] u_next [3];
    logic signed [31:0] k_next;
    logic signed [50:0] pk_neg [3];
    result_t            g_item_next;

    assign c_plus  = ONE + $signed({{(CW-EW){1'b0}}, cfg.eps});
    assign c_minus = ONE - $signed({{(CW-EW){1'b0}}, cfg.eps});

    assign rdy_g    = !g_valid_reg || out_ready;
    assign rdy_f    = !f_valid_reg || rdy_g;
    assign rdy_e    = !e_valid_reg || rdy_f;
    assign rdy_d    = !d_valid_reg || rdy_e;
    assign in_ready = rdy_d;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n[i]      = $signed(cfg.normal[i]);
            sn_neg[i] = -(51'(d_sn_reg[i]));
            u_wide[i] = 52'(sn_neg[i] >>> FRAC_BITS);
            if (i == 1) begin
                u_wide[i] = u_wide[i] + $signed({21'd0, d_r_reg});
            end
            u_next[i] = sat32(64'(u_wide[i]));
        end
        k_next = sat32(64'(d_kp_reg >>> FRAC_BITS));
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pk_neg[i] = -(51'(f_pk_reg[i]));
            g_item_next.pos_fix[i] = f_hit_reg ? sat32(64'(f_pu_reg[i] >>> FRAC_BITS))
                                               : '0;
            g_item_next.vel_fix[i] = f_hit_reg ? sat32(64'(pk_neg[i] >>> FRAC_BITS))
                                               : '0;
        end
        g_item_next.hit = f_hit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else begin
            if (rdy_d) begin
                d_valid_reg <= in_valid;
            end
            if (rdy_e) begin
                e_valid_reg <= d_valid_reg;
            end
            if (rdy_f) begin
                f_valid_reg <= e_valid_reg;
            end
            if (rdy_g) begin
                g_valid_reg <= f_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_d && in_valid) begin
            for (int i = 0; i < 3; i++) begin
                d_sn_reg[i] <= $signed(in_item.s) * n[i];
            end
            d_kp_reg  <= c_minus * $signed(in_item.w);
            d_r_reg   <= in_item.radius;
            d_hit_reg <= in_item.hit;
        end
        if (rdy_e && d_valid_reg) begin
            for (int i = 0; i < 3; i++) begin
                e_u_reg[i] <= u_next[i];
            end
            e_k_reg   <= k_next;
            e_hit_reg <= d_hit_reg;
        end
        if (rdy_f && e_valid_reg) begin
            for (int i = 0; i < 3; i++) begin
                f_pu_reg[i] <= c_plus * e_u_reg[i];
                f_pk_reg[i] <= e_k_reg * n[i];
            end
            f_hit_reg <= e_hit_reg;
        end
        if (rdy_g && f_valid_reg) begin
            g_item_reg <= g_item_next;
        end
    end

    assign out_valid = g_valid_reg;
    assign out_item  = g_item_reg;

endmodule

`default_nettype wire

[hdl/sphere_plane_collision_response_core.sv]
// sphere against plane collision response, one particle per transaction
//
// s_axis carries particles: center, velocity and radius in tdata, live flag in
// tuser. m_axis returns one result per particle: position and velocity
// corrections in tdata, hit flag in tuser. values are signed fixed point with
// FRAC_BITS fraction bits; corrections are zero when there is no hit.
// the plane (point, unit normal) and the coefficient e are written through the
// cfg port; cfg_ready is always high. the user must write them only while no
// particle is in flight; the block itself does not enforce this.
//
// three stages form the dot products and the hit test, four more build the
// corrections, the last being the output register. one particle is taken every
// cycle while m_axis_tready is high. when m_axis_tready is low the stages fill
// up behind the output register and s_axis_tready drops only once no stage is
// empty; nothing is lost or repeated. reset clears all stage valid bits and
// loads the default plane y = 0 with normal +y and e of about 0.1.
`default_nettype none

module sphere_plane_collision_response_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, sphere_radius, pad
    input  wire logic [223:0] s_axis_tdata,
    // is_alive
    input  wire logic         s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_fix_x, pos_fix_y, pos_fix_z, vel_fix_x, vel_fix_y, vel_fix_z
    output logic [191:0]      m_axis_tdata,
    // hit
    output logic              m_axis_tuser,

    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import spcr_pkg::*;

    cfg_t      cfg_reg;
    particle_t in_item;
    front_t    mid_item;
    result_t   out_item;
    logic      mid_valid, mid_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.point     <= {POINT_RESET, POINT_RESET, POINT_RESET};
            cfg_reg.normal[0] <= NORMAL_X_RESET;
            cfg_reg.normal[1] <= NORMAL_Y_RESET;
            cfg_reg.normal[2] <= NORMAL_Z_RESET;
            cfg_reg.eps       <= EPS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_POINT_X:  cfg_reg.point[0]  <= cfg_data;
                REG_POINT_Y:  cfg_reg.point[1]  <= cfg_data;
                REG_POINT_Z:  cfg_reg.point[2]  <= cfg_data;
                REG_NORMAL_X: cfg_reg.normal[0] <= cfg_data[NW-1:0];
                REG_NORMAL_Y: cfg_reg.normal[1] <= cfg_data[NW-1:0];
                REG_NORMAL_Z: cfg_reg.normal[2] <= cfg_data[NW-1:0];
                REG_EPS:      cfg_reg.eps       <= cfg_data[EW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_item.pos[i] = s_axis_tdata[QW*i +: QW];
            in_item.vel[i] = s_axis_tdata[3*QW + QW*i +: QW];
        end
        in_item.radius = s_axis_tdata[6*QW +: RW];
        in_item.alive  = s_axis_tuser;
    end

    spcr_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_item  (mid_item)
    );

    spcr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_item   (mid_item),
        .cfg       (cfg_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_axis_tdata[QW*i +: QW]        = out_item.pos_fix[i];
            m_axis_tdata[3*QW + QW*i +: QW] = out_item.vel_fix[i];
        end
        m_axis_tuser = out_item.hit;
    end

endmodule

`default_nettype wire
